// File: rtl/core/ppmfd_pkg.sv
// ----------------------------------------------------------------------------
// ppmfd_pkg
// Shared types and constants for the PPM frame decoder with clamp.
// ----------------------------------------------------------------------------
package ppmfd_pkg;

  localparam int MAX_CHANNELS = 16;
  localparam int CHAN_W       = 4;
  localparam int WIDTH_W      = 16;
  localparam int TS_W         = 32;
  localparam int CFG_IDX_W    = 2;

  localparam logic [WIDTH_W-1:0] WIDTH_MAX      = 16'hFFFF;
  localparam logic [WIDTH_W-1:0] PASS_MASK_RST  = 16'hFFFF;
  localparam logic [WIDTH_W-1:0] SYNC_GAP_RST   = 16'd2500;
  localparam logic [WIDTH_W-1:0] LIMIT_LOW_RST  = 16'h0000;
  localparam logic [WIDTH_W-1:0] LIMIT_HIGH_RST = 16'hFFFF;

  localparam logic KIND_EDGE  = 1'b0;
  localparam logic KIND_LIMIT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PASS_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_GAP  = 2'd1;

  typedef struct packed {
    logic               kind;
    logic [TS_W-1:0]    timestamp;
    logic               collision_avoid;
    logic [CHAN_W-1:0]  limit_channel;
    logic [WIDTH_W-1:0] limit_low;
    logic [WIDTH_W-1:0] limit_high;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  channel;
    logic [WIDTH_W-1:0] raw_width;
    logic               is_sync;
    logic               drive_valid;
    logic [WIDTH_W-1:0] drive_value;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    logic               en;
    logic [CHAN_W-1:0]  channel;
    logic [WIDTH_W-1:0] low;
    logic [WIDTH_W-1:0] high;
  } limit_wr_t;

endpackage

// File: rtl/core/ppmfd_limit_table.sv
// ----------------------------------------------------------------------------
// ppmfd_limit_table
// Per-channel clamp limit storage and the clamp applied to the drive width.
// ----------------------------------------------------------------------------
module ppmfd_limit_table import ppmfd_pkg::*; #(
  parameter int CHANNELS = MAX_CHANNELS
) (
  input  logic               clk,
  input  logic               rst,
  input  limit_wr_t          wr,
  input  logic [CHAN_W-1:0]  rd_channel,
  input  logic               clamp_en,
  input  logic [WIDTH_W-1:0] width,
  output logic [WIDTH_W-1:0] drive
);

  logic [WIDTH_W-1:0] low_limit  [MAX_CHANNELS];
  logic [WIDTH_W-1:0] high_limit [MAX_CHANNELS];
  logic [WIDTH_W-1:0] lo;
  logic [WIDTH_W-1:0] hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        low_limit[i]  <= LIMIT_LOW_RST;
        high_limit[i] <= LIMIT_HIGH_RST;
      end
    end else if (wr.en && ({1'b0, wr.channel} < (CHAN_W+1)'(CHANNELS))) begin
      low_limit[wr.channel]  <= wr.low;
      high_limit[wr.channel] <= wr.high;
    end
  end

  assign lo = low_limit[rd_channel];
  assign hi = high_limit[rd_channel];

  always_comb begin
    drive = width;
    if (clamp_en) begin
      if (width < lo) begin
        drive = lo;
      end else if (width > hi) begin
        drive = hi;
      end
    end
  end

endmodule

// File: rtl/core/ppm_frame_decoder_with_clamp_core.sv
// ----------------------------------------------------------------------------
// ppm_frame_decoder_with_clamp_core
// PPM frame decoder: edge timestamps in, per-channel widths and drive values out.
// ----------------------------------------------------------------------------
// Each input transaction is either an edge event or a limit write. An edge
// event yields exactly one registered result after acceptance: the interval
// since the previous edge (modulo 2^32, saturated at 65535), flagged as a sync
// when it reaches sync_gap, otherwise tagged with the current channel and, if
// that channel's pass_mask bit is set, a drive value clamped to the channel's
// limits in collision-avoid mode. Pulses beyond CHANNELS before a sync are
// flagged as overflow. A limit write gives no result. One transaction is taken
// every cycle; throughput is set by the single input register and the single
// result register, and drops only while the result register is stalled.
// Configuration writes are always ready and take effect on the next cycle.
module ppm_frame_decoder_with_clamp_core import ppmfd_pkg::*; #(
  parameter int CHANNELS = MAX_CHANNELS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WIDTH_W-1:0]   cfg_data
);

  localparam int CNT_W = $clog2(CHANNELS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CHANNELS);

  logic [WIDTH_W-1:0] pass_mask;
  logic [WIDTH_W-1:0] sync_gap;
  logic [TS_W-1:0]    last_edge_time;
  logic [CNT_W-1:0]   channel_index;

  logic               hold_valid;
  in_item_t           hold_data;

  logic               out_free;
  logic               proc;
  logic               proc_edge;
  logic [TS_W-1:0]    interval;
  logic [WIDTH_W-1:0] width;
  logic               sync_hit;
  logic               over_hit;
  logic [CHAN_W-1:0]  ch;
  logic [WIDTH_W-1:0] clamped;
  limit_wr_t          limit_wr;
  out_item_t          result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_mask <= PASS_MASK_RST;
      sync_gap  <= SYNC_GAP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PASS_MASK: pass_mask <= cfg_data;
        REG_SYNC_GAP:  sync_gap  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register and result register handshake
  assign out_free  = !out_valid || !out_stall;
  assign proc      = hold_valid && ((hold_data.kind == KIND_LIMIT) || out_free);
  assign proc_edge = proc && (hold_data.kind == KIND_EDGE);
  assign in_stall  = hold_valid && !proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      hold_valid <= 1'b1;
    end else if (proc) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_data <= in_data;
    end
  end

  // edge measurement
  assign interval = hold_data.timestamp - last_edge_time;
  assign width    = (|interval[TS_W-1:WIDTH_W]) ? WIDTH_MAX : interval[WIDTH_W-1:0];
  assign sync_hit = interval >= {{(TS_W-WIDTH_W){1'b0}}, sync_gap};
  assign over_hit = channel_index >= CNT_FULL;
  assign ch       = over_hit ? '0 : CHAN_W'(channel_index);

  assign limit_wr.en      = proc && (hold_data.kind == KIND_LIMIT);
  assign limit_wr.channel = hold_data.limit_channel;
  assign limit_wr.low     = hold_data.limit_low;
  assign limit_wr.high    = hold_data.limit_high;

  ppmfd_limit_table #(
    .CHANNELS (CHANNELS)
  ) u_limits (
    .clk        (clk),
    .rst        (rst),
    .wr         (limit_wr),
    .rd_channel (ch),
    .clamp_en   (hold_data.collision_avoid),
    .width      (width),
    .drive      (clamped)
  );

  always_comb begin
    result             = '0;
    result.raw_width   = width;
    if (sync_hit) begin
      result.is_sync = 1'b1;
    end else if (over_hit) begin
      result.overflow = 1'b1;
    end else begin
      result.channel = ch;
      if (pass_mask[ch]) begin
        result.drive_valid = 1'b1;
        result.drive_value = clamped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time <= '0;
      channel_index  <= '0;
    end else if (proc_edge) begin
      last_edge_time <= hold_data.timestamp;
      if (sync_hit) begin
        channel_index <= '0;
      end else if (over_hit) begin
        channel_index <= CNT_FULL;
      end else begin
        channel_index <= channel_index + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_edge) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_edge) begin
      out_data <= result;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    channel_index <= CNT_FULL)
    else $error("channel count past channel limit");

  a_sync_restarts: assert property (@(posedge clk) disable iff (rst)
    proc_edge && sync_hit |=> channel_index == '0)
    else $error("sync did not restart channel count");

  a_sync_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_sync |->
      out_data.channel == '0 && !out_data.drive_valid && !out_data.overflow)
    else $error("malformed sync result");

  a_overflow_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.overflow |->
      out_data.channel == '0 && !out_data.drive_valid)
    else $error("malformed overflow result");

  a_drive_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.drive_valid |-> out_data.drive_value == '0)
    else $error("drive value set without drive valid");

  a_limit_no_result: assert property (@(posedge clk) disable iff (rst)
    limit_wr.en |=> $stable(last_edge_time) && $stable(channel_index))
    else $error("limit write disturbed edge state");

endmodule

// File: verif/tb_ppm_frame_decoder_with_clamp_core.sv
// ----------------------------------------------------------------------------
// tb_ppm_frame_decoder_with_clamp_core
// Self-checking bench for the PPM frame decoder with per-channel clamping.
// Edge and limit-load transactions are driven with random gaps while a
// scoreboard decodes the same stream and checks every result field by field.
// Directed cases cover wrap, saturation, sync threshold and clamp limits,
// then channel overrun, register sweeps, a receiver hold-off and random frames.
// ----------------------------------------------------------------------------
module tb_ppm_frame_decoder_with_clamp_core;
  import ppmfd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_ITEMS  = 450;
  localparam int DRAIN_WAIT  = 4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WIDTH_W-1:0]   cfg_data = '0;

  // scoreboard copy of the decoder state
  logic [TS_W-1:0]    last_edge;
  int                 chan_idx;
  logic [WIDTH_W-1:0] low_tab [MAX_CHANNELS];
  logic [WIDTH_W-1:0] high_tab [MAX_CHANNELS];
  logic [WIDTH_W-1:0] pass_mask;
  logic [WIDTH_W-1:0] sync_gap;

  out_item_t expected_pulses [$];
  out_item_t want;

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  logic hold_rx = 1'b0;

  int cycle_cnt = 0;
  int n_bad = 0;
  int n_items = 0;
  int n_checked = 0;
  int n_sync = 0;
  int n_overflow = 0;
  int n_driven = 0;
  int n_limit = 0;
  int n_cfg = 0;

  ppm_frame_decoder_with_clamp_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_pulses.size());
      $display("tb_ppm_frame_decoder_with_clamp_core: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_rx) begin
      out_stall <= 1'b1;
    end else if (rx_idle_on) begin
      out_stall <= ($urandom_range(99) < 32);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_pulses.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) begin
          $display("unexpected result: ch %0d raw %0d sync %0b dv %0b drive %0d ovf %0b",
                   out_data.channel, out_data.raw_width, out_data.is_sync,
                   out_data.drive_valid, out_data.drive_value, out_data.overflow);
        end
      end else begin
        want = expected_pulses.pop_front();
        n_checked++;
        if (out_data.channel !== want.channel || out_data.raw_width !== want.raw_width ||
            out_data.is_sync !== want.is_sync || out_data.drive_valid !== want.drive_valid ||
            out_data.drive_value !== want.drive_value ||
            out_data.overflow !== want.overflow) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("mismatch at result %0d:", n_checked);
            $display("  expected ch %0d raw %0d sync %0b dv %0b drive %0d ovf %0b",
                     want.channel, want.raw_width, want.is_sync, want.drive_valid,
                     want.drive_value, want.overflow);
            $display("  actual   ch %0d raw %0d sync %0b dv %0b drive %0d ovf %0b",
                     out_data.channel, out_data.raw_width, out_data.is_sync,
                     out_data.drive_valid, out_data.drive_value, out_data.overflow);
          end
        end
      end
    end
  end

  function automatic void decoder_reset();
    last_edge = '0;
    chan_idx  = 0;
    pass_mask = PASS_MASK_RST;
    sync_gap  = SYNC_GAP_RST;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      low_tab[i]  = LIMIT_LOW_RST;
      high_tab[i] = LIMIT_HIGH_RST;
    end
  endfunction

  // decode one accepted transaction and queue the pulse if it is an edge
  function automatic void decode_edge(input in_item_t it);
    logic [TS_W-1:0]    gap_us;
    logic [WIDTH_W-1:0] w;
    logic [WIDTH_W-1:0] d;
    logic [CHAN_W-1:0]  c;
    out_item_t          r;
    n_items++;
    if (it.kind == KIND_LIMIT) begin
      low_tab[it.limit_channel]  = it.limit_low;
      high_tab[it.limit_channel] = it.limit_high;
      n_limit++;
      return;
    end
    gap_us    = it.timestamp - last_edge;
    last_edge = it.timestamp;
    w = (gap_us > TS_W'(WIDTH_MAX)) ? WIDTH_MAX : gap_us[WIDTH_W-1:0];
    r = '0;
    r.raw_width = w;
    if (gap_us >= TS_W'(sync_gap)) begin
      chan_idx  = 0;
      r.is_sync = 1'b1;
      n_sync++;
    end else if (chan_idx >= MAX_CHANNELS) begin
      r.overflow = 1'b1;
      n_overflow++;
    end else begin
      c = chan_idx[CHAN_W-1:0];
      r.channel = c;
      if (pass_mask[c]) begin
        d = w;
        if (it.collision_avoid) begin
          if (d < low_tab[c]) begin
            d = low_tab[c];
          end else if (d > high_tab[c]) begin
            d = high_tab[c];
          end
        end
        r.drive_valid = 1'b1;
        r.drive_value = d;
        n_driven++;
      end
      chan_idx++;
    end
    expected_pulses.push_back(r);
  endfunction

  task automatic send_item(input in_item_t it);
    while (tx_idle_on && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_edge(it);
  endtask

  task automatic send_edge_at(input logic [TS_W-1:0] ts, input logic avoid);
    in_item_t it;
    it.kind            = KIND_EDGE;
    it.timestamp       = ts;
    it.collision_avoid = avoid;
    it.limit_channel   = CHAN_W'($urandom);
    it.limit_low       = WIDTH_W'($urandom);
    it.limit_high      = WIDTH_W'($urandom);
    send_item(it);
  endtask

  task automatic send_edge(input logic [TS_W-1:0] gap_us, input logic avoid);
    send_edge_at(last_edge + gap_us, avoid);
  endtask

  task automatic send_limit(input logic [CHAN_W-1:0] ch, input logic [WIDTH_W-1:0] lo,
                            input logic [WIDTH_W-1:0] hi);
    in_item_t it;
    it.kind            = KIND_LIMIT;
    it.timestamp       = $urandom;
    it.collision_avoid = 1'($urandom_range(1));
    it.limit_channel   = ch;
    it.limit_low       = lo;
    it.limit_high      = hi;
    send_item(it);
  endtask

  task automatic send_random_limit();
    if ($urandom_range(99) < 70) begin
      send_limit(CHAN_W'($urandom), WIDTH_W'($urandom_range(600, 1400)),
                 WIDTH_W'($urandom_range(1600, 2400)));
    end else begin
      send_limit(CHAN_W'($urandom), WIDTH_W'($urandom), WIDTH_W'($urandom));
    end
  endtask

  function automatic logic [TS_W-1:0] pick_pulse_width();
    if (sync_gap == 0) begin
      return TS_W'($urandom_range(0, 3000));
    end
    if (sync_gap > 2200 && $urandom_range(99) < 85) begin
      return TS_W'($urandom_range(800, 2200));
    end
    return TS_W'($urandom_range(0, sync_gap - 1));
  endfunction

  // one sync gap followed by n channel pulses, with loads and noise mixed in
  task automatic send_frame(input int n);
    logic avoid;
    logic [TS_W-1:0] extra;
    avoid = 1'($urandom_range(1));
    extra = ($urandom_range(9) == 0) ? TS_W'($urandom_range(0, 32'h7FFF_FFFF))
                                     : TS_W'($urandom_range(0, 3000));
    send_edge(TS_W'(sync_gap) + extra, avoid);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 10) begin
        send_random_limit();
      end
      if ($urandom_range(99) < 4) begin
        send_edge_at($urandom, 1'($urandom_range(1)));
      end
      send_edge(pick_pulse_width(), ($urandom_range(99) < 85) ? avoid : ~avoid);
    end
  endtask

  task automatic send_random_frame();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      send_frame($urandom_range(17, 20));
    end else if (pick < 20) begin
      send_frame($urandom_range(0, 3));
    end else begin
      send_frame($urandom_range(6, 16));
    end
  endtask

  // wait until every pulse is out and the pipeline is empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pulses.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIDTH_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_cfg++;
    case (idx)
      REG_PASS_MASK: pass_mask = val;
      REG_SYNC_GAP:  sync_gap  = val;
      default: ;
    endcase
  endtask

  task automatic test_directed();
    send_edge(0, 1'b0);
    send_edge(2499, 1'b0);
    send_edge(2500, 1'b0);
    send_edge(1500, 1'b0);
    send_edge(32'h0002_0000, 1'b0);
    send_edge_at(32'hFFFF_FF00, 1'b1);
    send_edge_at(32'h0000_0100, 1'b0);
    send_limit(4'd0, 16'd1000, 16'd2000);
    send_limit(4'd1, 16'd3000, 16'd500);
    send_limit(4'd2, 16'hFFFF, 16'hFFFF);
    send_limit(4'd15, 16'd0, 16'd0);
    send_edge(3000, 1'b1);
    send_edge(500, 1'b1);
    send_edge(2000, 1'b1);
    send_edge(1, 1'b1);
    send_edge(2400, 1'b0);
    send_edge(32'h0000_FFFF, 1'b1);
    send_edge(2400, 1'b1);
    send_edge(400, 1'b1);
    send_edge(1200, 1'b1);
    drain();
  endtask

  task automatic test_overrun();
    send_frame(MAX_CHANNELS + 3);
    send_frame(MAX_CHANNELS);
    drain();
  endtask

  task automatic test_register_sweep();
    logic [WIDTH_W-1:0] masks [6];
    logic [WIDTH_W-1:0] gaps [6];
    masks = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h0000, 16'h0000};
    gaps  = '{16'd1, 16'hFFFF, 16'd0, 16'd2500, 16'd0, 16'd0};
    masks[4] = WIDTH_W'($urandom);
    masks[5] = WIDTH_W'($urandom);
    gaps[4]  = WIDTH_W'($urandom_range(1500, 4000));
    gaps[5]  = WIDTH_W'($urandom_range(1, 65535));
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_PASS_MASK, masks[p]);
      write_reg(REG_SYNC_GAP, gaps[p]);
      repeat (4) send_random_frame();
      drain();
    end
    write_reg(REG_SPARE_A, WIDTH_W'($urandom));
    write_reg(REG_SPARE_B, WIDTH_W'($urandom));
    send_random_frame();
    drain();
  endtask

  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    fork
      begin
        hold_rx <= 1'b1;
        repeat (80) @(posedge clk);
        hold_rx <= 1'b0;
      end
    join_none
    send_frame(MAX_CHANNELS + 2);
    send_frame(12);
    drain();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_random_frames();
    int stop_at;
    write_reg(REG_PASS_MASK, WIDTH_W'($urandom));
    write_reg(REG_SYNC_GAP, WIDTH_W'($urandom_range(2000, 3000)));
    stop_at = n_items + RAND_ITEMS;
    while (n_items < stop_at) begin
      tx_idle_on = !(n_items > stop_at - 350 && n_items < stop_at - 200);
      rx_idle_on = tx_idle_on;
      send_random_frame();
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    drain();
  endtask

  initial begin
    decoder_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_overrun();
    test_register_sweep();
    test_backpressure();
    test_random_frames();
    repeat (10) @(posedge clk);
    if (expected_pulses.size() != 0) begin
      n_bad++;
      $display("%0d expected results never arrived", expected_pulses.size());
    end
    $display("checked %0d edge results (%0d syncs, %0d overflow, %0d driven)",
             n_checked, n_sync, n_overflow, n_driven);
    $display("from %0d transactions incl. %0d limit loads, %0d register writes, %0d cycles",
             n_items, n_limit, n_cfg, cycle_cnt);
    if (n_bad == 0) begin
      $display("tb_ppm_frame_decoder_with_clamp_core: clean");
    end else begin
      $display("tb_ppm_frame_decoder_with_clamp_core: errors");
    end
    $finish;
  end

endmodule
